[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/nubx_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA / UBX framer package
// Shared constants, status codes, tally strobes and the hex digit decoder.
// ----------------------------------------------------------------------------
package nubx_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 9;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LENGTH_LIMIT = 4'd0,
		REG_IDLE_FILL    = 4'd1
	} reg_index_t;

	localparam logic [8:0] LIMIT_RESET = 9'd160;
	localparam logic [7:0] FILL_RESET  = 8'hFF;
	localparam logic [8:0] LIMIT_MIN   = 9'd3;
	localparam logic [8:0] LIMIT_MAX   = 9'd256;

	// Default tally width.
	localparam int COUNT_WIDTH_DEF = 32;

	// Framing characters.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] UBX_SYNC1 = 8'hB5;
	localparam logic [7:0] UBX_SYNC2 = 8'h62;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_NMEA_OK   = 3'd0,
		ST_UBX_OK    = 3'd1,
		ST_NMEA_BAD  = 3'd2,
		ST_NMEA_LONG = 3'd3,
		ST_UBX_BAD   = 3'd4
	} status_t;

	// Tally slots.
	localparam int TALLY_N = 4;
	localparam int T_TEXT  = 0;
	localparam int T_BIN   = 1;
	localparam int T_ERR   = 2;
	localparam int T_BYTES = 3;

	typedef struct packed {
		logic bytes;
		logic err;
		logic bin;
		logic text;
	} tally_inc_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	// Decode one ASCII hex digit, either case.
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.value = c[3:0] + 4'd9;
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

[design/nubx_if.sv]
// ----------------------------------------------------------------------------
// NMEA / UBX framer channels
// Valid/ready channel interfaces for received bytes and frame results.
// ----------------------------------------------------------------------------
interface nubx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface nubx_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_status;
	logic [7:0]  packet_class;
	logic [7:0]  packet_id;
	logic [15:0] payload_length;
	logic [7:0]  sentence_length;
	logic [31:0] good_text_count;
	logic [31:0] good_binary_count;
	logic [31:0] error_count;
	logic [31:0] byte_count;

	modport source(output valid, output frame_status, output packet_class,
		output packet_id, output payload_length, output sentence_length,
		output good_text_count, output good_binary_count, output error_count,
		output byte_count, input ready);
	modport sink(input valid, input frame_status, input packet_class,
		input packet_id, input payload_length, input sentence_length,
		input good_text_count, input good_binary_count, input error_count,
		input byte_count, output ready);
endinterface

[design/nubx_tally.sv]
// ----------------------------------------------------------------------------
// NMEA / UBX framer tallies
// Four wrapping event counters with their post-increment values exposed.
// ----------------------------------------------------------------------------
module nubx_tally #(
	parameter int COUNT_WIDTH = nubx_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nubx_pkg::tally_inc_t   inc,
	output logic [COUNT_WIDTH-1:0] next_cnt [nubx_pkg::TALLY_N]
);
	import nubx_pkg::*;

	logic [COUNT_WIDTH-1:0] cnt_q [TALLY_N];
	logic [TALLY_N-1:0]     inc_vec;

	// Strobes in slot order.
	assign inc_vec[T_TEXT]  = inc.text;
	assign inc_vec[T_BIN]   = inc.bin;
	assign inc_vec[T_ERR]   = inc.err;
	assign inc_vec[T_BYTES] = inc.bytes;

	// Values after this cycle's events.
	always_comb begin
		for (int i = 0; i < TALLY_N; i++) begin
			next_cnt[i] = cnt_q[i] + COUNT_WIDTH'(inc_vec[i]);
		end
	end

	// Counter storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TALLY_N; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < TALLY_N; i++) begin
				cnt_q[i] <= next_cnt[i];
			end
		end
	end

endmodule

[design/nmea_ubx_stream_framer_top.sv]
// ----------------------------------------------------------------------------
// NMEA / UBX stream framer
// Frames NMEA text sentences and UBX binary packets from a receiver byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle from the din channel while the
// result register is free or dout takes its result. Each byte is first held
// in an input register; from there the framer state, the checksum and the
// tallies are updated from it in one pass, and a finished frame lands in the
// result register, from which it is offered on dout until it is taken. The
// update of the framer state from the registered byte in one pass sets that
// rate. The input stays ready while a result waits, and drops only when the
// input register and the result register are both full and dout is stalled.
// There is no clearing pass after reset. Configuration writes must be made
// while no frame is in progress.
module nmea_ubx_stream_framer_top #(
	parameter int COUNT_WIDTH = nubx_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [nubx_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [nubx_pkg::CFG_DATA_W-1:0]  cfg_data,
	nubx_in_if.sink                          din,
	nubx_out_if.source                       dout
);
	import nubx_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		PH_WAIT, PH_TEXT, PH_SYNC2, PH_CLASS, PH_ID,
		PH_LENL, PH_LENH, PH_PAYLOAD, PH_CKA, PH_CKB
	} phase_t;

	typedef enum logic [1:0] {
		CK_ACCUM, CK_DIGIT1, CK_DIGIT2, CK_DONE
	} ck_t;

	// Configuration registers.
	logic [8:0] limit_q;
	logic [7:0] fill_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Framer state.
	phase_t      phase_q, phase_d;
	logic [7:0]  tidx_q, tidx_d;
	logic [7:0]  txor_q, txor_d;
	ck_t         tck_q, tck_d;
	logic [7:0]  texp_q, texp_d;
	logic        tbad_q, tbad_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pcnt_q, pcnt_d;
	logic [7:0]  suma_q, suma_d;
	logic [7:0]  sumb_q, sumb_d;
	logic [7:0]  rsuma_q, rsuma_d;

	// Result register.
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  class_out_q;
	logic [7:0]  id_out_q;
	logic [15:0] len_out_q;
	logic [7:0]  slen_q;
	logic [31:0] text_cnt_q;
	logic [31:0] bin_cnt_q;
	logic [31:0] err_cnt_q;
	logic [31:0] byte_cnt_q;

	// Combinational helpers.
	logic        consume;
	logic        drop;
	logic        step;
	logic [8:0]  lim_m1;
	logic [7:0]  b;
	hex_t        hx;
	logic        tbad_n;
	ck_t         tck_n;
	logic [7:0]  txor_n;
	logic [7:0]  texp_n;
	logic [7:0]  fa;
	logic [7:0]  fb;
	logic [15:0] pcnt_inc;
	logic        emit;
	status_t     status;
	logic [7:0]  slen;
	tally_inc_t  inc;
	tally_inc_t  inc_g;
	logic        out_is_bin;
	logic [COUNT_WIDTH-1:0] next_cnt [TALLY_N];

	// Handshake: the stored byte moves on whenever the result register can take
	// whatever it produces.
	assign consume   = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || consume;
	assign b         = byte_s1;
	assign drop      = (phase_q == PH_WAIT) && (b == fill_q);
	assign step      = consume && !drop;

	// Clamped sentence limit, minus one.
	always_comb begin
		if (limit_q < LIMIT_MIN) begin
			lim_m1 = LIMIT_MIN - 9'd1;
		end else if (limit_q > LIMIT_MAX) begin
			lim_m1 = LIMIT_MAX - 9'd1;
		end else begin
			lim_m1 = limit_q - 9'd1;
		end
	end

	// Sentence checksum tracker for one character.
	assign hx = hex_digit(b);
	always_comb begin
		tbad_n = tbad_q;
		tck_n  = tck_q;
		txor_n = txor_q;
		texp_n = texp_q;
		if (!tbad_q) begin
			unique case (tck_q)
				CK_ACCUM: begin
					if (b == CH_NUL || b == CH_CR || b == CH_LF) begin
						tbad_n = 1'b1;
					end else if (b == CH_STAR) begin
						tck_n = CK_DIGIT1;
					end else begin
						txor_n = txor_q ^ b;
					end
				end
				CK_DIGIT1, CK_DIGIT2: begin
					if (!hx.valid) begin
						tbad_n = 1'b1;
					end else begin
						texp_n = {texp_q[3:0], hx.value};
						tck_n  = (tck_q == CK_DIGIT1) ? CK_DIGIT2 : CK_DONE;
					end
				end
				CK_DONE: begin
				end
			endcase
		end
	end

	// Fletcher sums and payload position.
	assign fa       = suma_q + b;
	assign fb       = sumb_q + fa;
	assign pcnt_inc = pcnt_q + 16'd1;

	// Framer next state and result.
	always_comb begin
		phase_d = phase_q;
		tidx_d  = tidx_q;
		txor_d  = txor_q;
		tck_d   = tck_q;
		texp_d  = texp_q;
		tbad_d  = tbad_q;
		class_d = class_q;
		id_d    = id_q;
		len_d   = len_q;
		pcnt_d  = pcnt_q;
		suma_d  = suma_q;
		sumb_d  = sumb_q;
		rsuma_d = rsuma_q;
		emit    = 1'b0;
		status  = ST_NMEA_OK;
		slen    = 8'd0;
		inc     = '0;
		inc.bytes = 1'b1;
		unique case (phase_q)
			PH_WAIT: begin
				if (b == CH_DOLLAR) begin
					phase_d = PH_TEXT;
					tidx_d  = 8'd1;
					txor_d  = 8'd0;
					tck_d   = CK_ACCUM;
					texp_d  = 8'd0;
					tbad_d  = 1'b0;
				end else if (b == UBX_SYNC1) begin
					phase_d = PH_SYNC2;
				end
			end
			PH_TEXT: begin
				if (b == CH_DOLLAR) begin
					// A new start discards the sentence in progress.
					tidx_d = 8'd1;
					txor_d = 8'd0;
					tck_d  = CK_ACCUM;
					texp_d = 8'd0;
					tbad_d = 1'b0;
				end else if ({1'b0, tidx_q} < lim_m1) begin
					tidx_d = tidx_q + 8'd1;
					txor_d = txor_n;
					tck_d  = tck_n;
					texp_d = texp_n;
					tbad_d = tbad_n;
					if (b == CH_LF) begin
						emit    = 1'b1;
						slen    = tidx_q + 8'd1;
						phase_d = PH_WAIT;
						tidx_d  = 8'd0;
						if (!tbad_n && tck_n == CK_DONE && txor_n == texp_n) begin
							status   = ST_NMEA_OK;
							inc.text = 1'b1;
						end else begin
							status  = ST_NMEA_BAD;
							inc.err = 1'b1;
						end
					end
				end else begin
					// Buffer full: the byte is dropped and the sentence rejected.
					emit    = 1'b1;
					slen    = tidx_q;
					status  = ST_NMEA_LONG;
					inc.err = 1'b1;
					tidx_d  = 8'd0;
					phase_d = PH_WAIT;
				end
			end
			PH_SYNC2: begin
				if (b == UBX_SYNC2) begin
					suma_d  = 8'd0;
					sumb_d  = 8'd0;
					phase_d = PH_CLASS;
				end else if (b != UBX_SYNC1) begin
					phase_d = PH_WAIT;
				end
			end
			PH_CLASS: begin
				class_d = b;
				suma_d  = fa;
				sumb_d  = fb;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = b;
				suma_d  = fa;
				sumb_d  = fb;
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				len_d   = {8'h00, b};
				suma_d  = fa;
				sumb_d  = fb;
				phase_d = PH_LENH;
			end
			PH_LENH: begin
				len_d   = {b, len_q[7:0]};
				suma_d  = fa;
				sumb_d  = fb;
				pcnt_d  = 16'd0;
				phase_d = ({b, len_q[7:0]} == 16'd0) ? PH_CKA : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				suma_d = fa;
				sumb_d = fb;
				pcnt_d = pcnt_inc;
				if (pcnt_inc >= len_q) begin
					phase_d = PH_CKA;
				end
			end
			PH_CKA: begin
				rsuma_d = b;
				phase_d = PH_CKB;
			end
			PH_CKB: begin
				phase_d = PH_WAIT;
				emit    = 1'b1;
				if (rsuma_q == suma_q && b == sumb_q) begin
					status  = ST_UBX_OK;
					inc.bin = 1'b1;
				end else begin
					status  = ST_UBX_BAD;
					inc.err = 1'b1;
				end
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	assign inc_g = step ? inc : '0;

	nubx_tally #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.inc      (inc_g),
		.next_cnt (next_cnt)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			fill_q  <= FILL_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_LENGTH_LIMIT) begin
				limit_q <= cfg_data;
			end else if (cfg_index == REG_IDLE_FILL) begin
				fill_q <= cfg_data[7:0];
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			byte_s1 <= din.rx_byte;
		end
	end

	// Framer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			tidx_q  <= 8'd0;
			txor_q  <= 8'd0;
			tck_q   <= CK_ACCUM;
			texp_q  <= 8'd0;
			tbad_q  <= 1'b0;
			class_q <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 16'd0;
			pcnt_q  <= 16'd0;
			suma_q  <= 8'd0;
			sumb_q  <= 8'd0;
			rsuma_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			tidx_q  <= tidx_d;
			txor_q  <= txor_d;
			tck_q   <= tck_d;
			texp_q  <= texp_d;
			tbad_q  <= tbad_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			pcnt_q  <= pcnt_d;
			suma_q  <= suma_d;
			sumb_q  <= sumb_d;
			rsuma_q <= rsuma_d;
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload.
	always_ff @(posedge clk) begin
		if (step && emit) begin
			status_q    <= status;
			class_out_q <= class_q;
			id_out_q    <= id_q;
			len_out_q   <= len_q;
			slen_q      <= slen;
			text_cnt_q  <= 32'(next_cnt[T_TEXT]);
			bin_cnt_q   <= 32'(next_cnt[T_BIN]);
			err_cnt_q   <= 32'(next_cnt[T_ERR]);
			byte_cnt_q  <= 32'(next_cnt[T_BYTES]);
		end
	end

	assign dout.valid             = out_valid_q;
	assign dout.frame_status      = status_q;
	assign dout.packet_class      = class_out_q;
	assign dout.packet_id         = id_out_q;
	assign dout.payload_length    = len_out_q;
	assign dout.sentence_length   = slen_q;
	assign dout.good_text_count   = text_cnt_q;
	assign dout.good_binary_count = bin_cnt_q;
	assign dout.error_count       = err_cnt_q;
	assign dout.byte_count        = byte_cnt_q;

	// The held result comes from a binary packet.
	assign out_is_bin = (status_q == ST_UBX_OK) || (status_q == ST_UBX_BAD);

	// Checks on the framer and its pipeline.
	`AST_NEXT(a_emit_lands, step && emit, out_valid_q, "finished frame did not reach result")
	`AST_ALWAYS(a_text_index, (phase_q != PH_TEXT) || (tidx_q != 8'd0), "empty text index")
	`AST_ALWAYS(a_bin_slen, !out_valid_q || !out_is_bin || (slen_q == 8'd0), "binary slen")
	`AST_ALWAYS(a_stall_cause, din.ready || (valid_s1 && out_valid_q && !dout.ready), "stall")

endmodule

[tb/nmea_ubx_stream_framer_top_tb.sv]
// ----------------------------------------------------------------------------
// NMEA / UBX stream framer testbench
// Feeds byte streams of text sentences, binary packets, broken frames and noise
// into the framer. A shadow copy of the framer tracks every accepted byte and
// queues the frame report that each finished frame must produce; a monitor
// compares every report the block hands out against that queue.
// ----------------------------------------------------------------------------
module nmea_ubx_stream_framer_top_tb;
	import nubx_pkg::*;

	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] octets_t[$];

	typedef enum logic [3:0] {
		FP_WAIT, FP_TEXT, FP_SYNC2, FP_CLASS, FP_ID,
		FP_LENL, FP_LENH, FP_PAYLOAD, FP_CKA, FP_CKB
	} frame_phase_t;

	typedef enum logic [1:0] {
		CK_ACCUM, CK_DIGIT1, CK_DIGIT2, CK_DONE
	} sum_phase_t;

	typedef struct {
		status_t     status;
		logic [7:0]  pkt_class;
		logic [7:0]  pkt_id;
		logic [15:0] pkt_len;
		logic [7:0]  text_len;
		logic [31:0] n_text;
		logic [31:0] n_bin;
		logic [31:0] n_err;
		logic [31:0] n_bytes;
	} frame_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	nubx_in_if  din();
	nubx_out_if dout();

	nmea_ubx_stream_framer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.din      (din),
		.dout     (dout)
	);

	always #1 clk = ~clk;

	// Shadow framer state and its copy of the registers.
	logic [8:0]   cfg_limit = LIMIT_RESET;
	logic [7:0]   cfg_fill = FILL_RESET;
	frame_phase_t phase = FP_WAIT;
	logic [7:0]   txt_len = '0;
	logic [7:0]   txt_xor = '0;
	sum_phase_t   sum_phase = CK_ACCUM;
	logic [7:0]   txt_want = '0;
	logic         txt_bad = 1'b0;
	logic [7:0]   pkt_class = '0;
	logic [7:0]   pkt_id = '0;
	logic [15:0]  pkt_len = '0;
	logic [15:0]  pay_seen = '0;
	logic [7:0]   fl_a = '0;
	logic [7:0]   fl_b = '0;
	logic [7:0]   got_a = '0;
	logic [31:0]  n_text = '0;
	logic [31:0]  n_bin = '0;
	logic [31:0]  n_err = '0;
	logic [31:0]  n_bytes = '0;

	frame_report_t pending_reports[$];
	int            mismatches = 0;
	int            bytes_taken = 0;
	bit            steady = 1'b0;

	// The length limit clamps to the range the buffer supports.
	function automatic logic [8:0] eff_limit();
		if (cfg_limit < LIMIT_MIN) return LIMIT_MIN;
		if (cfg_limit > LIMIT_MAX) return LIMIT_MAX;
		return cfg_limit;
	endfunction

	task automatic push_report(input status_t st, input logic [7:0] slen);
		frame_report_t r;
		r.status    = st;
		r.pkt_class = pkt_class;
		r.pkt_id    = pkt_id;
		r.pkt_len   = pkt_len;
		r.text_len  = slen;
		r.n_text    = n_text;
		r.n_bin     = n_bin;
		r.n_err     = n_err;
		r.n_bytes   = n_bytes;
		pending_reports.push_back(r);
	endtask

	task automatic open_sentence();
		txt_len   = 8'd1;
		txt_xor   = '0;
		sum_phase = CK_ACCUM;
		txt_want  = '0;
		txt_bad   = 1'b0;
	endtask

	task automatic fletcher(input logic [7:0] b);
		fl_a = fl_a + b;
		fl_b = fl_b + fl_a;
	endtask

	// Advance the shadow framer by one accepted byte and queue any report.
	task automatic predict_frame_byte(input logic [7:0] b, output bit taken);
		logic [8:0] lim;
		logic [7:0] n;
		int         nib;
		lim = eff_limit();
		taken = !(phase == FP_WAIT && b == cfg_fill);
		if (!taken) return;
		n_bytes++;
		case (phase)
			FP_WAIT: begin
				if (b == CH_DOLLAR) begin
					open_sentence();
					phase = FP_TEXT;
				end else if (b == UBX_SYNC1) begin
					phase = FP_SYNC2;
				end
			end
			FP_TEXT: begin
				if (b == CH_DOLLAR) begin
					open_sentence();
				end else if ({1'b0, txt_len} < lim - 9'd1) begin
					txt_len++;
					// Checksum tracking stops once the sentence is marked bad.
					if (!txt_bad) begin
						case (sum_phase)
							CK_ACCUM: begin
								if (b == CH_NUL || b == CH_CR || b == CH_LF) txt_bad = 1'b1;
								else if (b == CH_STAR) sum_phase = CK_DIGIT1;
								else txt_xor ^= b;
							end
							CK_DIGIT1, CK_DIGIT2: begin
								if (b >= "0" && b <= "9") nib = b - 8'h30;
								else if (b >= "A" && b <= "F") nib = b - 8'h37;
								else if (b >= "a" && b <= "f") nib = b - 8'h57;
								else nib = -1;
								if (nib < 0) begin
									txt_bad = 1'b1;
								end else begin
									txt_want  = {txt_want[3:0], nib[3:0]};
									sum_phase = (sum_phase == CK_DIGIT1) ? CK_DIGIT2 : CK_DONE;
								end
							end
							default: ;
						endcase
					end
					if (b == CH_LF) begin
						n = txt_len;
						phase = FP_WAIT;
						txt_len = '0;
						if (!txt_bad && sum_phase == CK_DONE && txt_xor == txt_want) begin
							n_text++;
							push_report(ST_NMEA_OK, n);
						end else begin
							n_err++;
							push_report(ST_NMEA_BAD, n);
						end
					end
				end else begin
					// Buffer full: the byte is dropped and the sentence is rejected.
					n_err++;
					push_report(ST_NMEA_LONG, txt_len);
					txt_len = '0;
					phase = FP_WAIT;
				end
			end
			FP_SYNC2: begin
				if (b == UBX_SYNC2) begin
					fl_a = '0;
					fl_b = '0;
					phase = FP_CLASS;
				end else if (b != UBX_SYNC1) begin
					phase = FP_WAIT;
				end
			end
			FP_CLASS: begin
				pkt_class = b;
				fletcher(b);
				phase = FP_ID;
			end
			FP_ID: begin
				pkt_id = b;
				fletcher(b);
				phase = FP_LENL;
			end
			FP_LENL: begin
				pkt_len = {8'h00, b};
				fletcher(b);
				phase = FP_LENH;
			end
			FP_LENH: begin
				pkt_len[15:8] = b;
				fletcher(b);
				pay_seen = '0;
				phase = (pkt_len == 16'd0) ? FP_CKA : FP_PAYLOAD;
			end
			FP_PAYLOAD: begin
				fletcher(b);
				pay_seen++;
				if (pay_seen >= pkt_len) phase = FP_CKA;
			end
			FP_CKA: begin
				got_a = b;
				phase = FP_CKB;
			end
			default: begin
				phase = FP_WAIT;
				if (got_a == fl_a && b == fl_b) begin
					n_bin++;
					push_report(ST_UBX_OK, 8'd0);
				end else begin
					n_err++;
					push_report(ST_UBX_BAD, 8'd0);
				end
			end
		endcase
	endtask

	// Offer one byte, with an occasional gap first, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		bit taken;
		if (!steady) begin
			while ($urandom_range(99) < 9) begin
				din.valid <= 1'b0;
				@(posedge clk);
			end
		end
		din.valid   <= 1'b1;
		din.rx_byte <= b;
		@(posedge clk);
		while (din.ready !== 1'b1) @(posedge clk);
		predict_frame_byte(b, taken);
		if (taken) bytes_taken++;
	endtask

	task automatic send_octets(input octets_t f);
		foreach (f[i]) send_byte(f[i]);
	endtask

	// Close any open frame, then let every report and the pipeline drain.
	task automatic quiesce();
		while (phase != FP_WAIT) send_byte(phase == FP_TEXT ? CH_LF : 8'h00);
		din.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [8:0] value);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LENGTH_LIMIT) cfg_limit = value;
		else cfg_fill = value[7:0];
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
		if (v < 4'd10) return 8'h30 + v;
		return (lower ? 8'h57 : 8'h37) + v;
	endfunction

	function automatic octets_t text_octets(input string s);
		octets_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// Random bytes; text-safe bytes avoid the framing and control characters.
	function automatic octets_t random_bytes(input int n, input bit text_safe);
		octets_t    q;
		logic [7:0] c;
		repeat (n) begin
			do c = 8'($urandom);
			while (text_safe && (c == CH_DOLLAR || c == CH_STAR || c == CH_CR ||
				c == CH_LF || c == CH_NUL));
			q.push_back(c);
		end
		return q;
	endfunction

	// Full sentence with CR LF; flip corrupts the checksum digits.
	function automatic octets_t nmea_frame(input octets_t body, input bit lower,
		input logic [7:0] flip);
		octets_t    f;
		logic [7:0] x;
		x = flip;
		foreach (body[i]) x ^= body[i];
		f.push_back(CH_DOLLAR);
		foreach (body[i]) f.push_back(body[i]);
		f.push_back(CH_STAR);
		f.push_back(hex_char(x[7:4], lower));
		f.push_back(hex_char(x[3:0], lower));
		f.push_back(CH_CR);
		f.push_back(CH_LF);
		return f;
	endfunction

	// Full binary packet; nonzero flips corrupt the check bytes.
	function automatic octets_t ubx_frame(input logic [7:0] cls, input logic [7:0] id,
		input octets_t payload, input logic [7:0] flip_a, input logic [7:0] flip_b);
		octets_t     f;
		logic [7:0]  a;
		logic [7:0]  s;
		logic [15:0] len;
		len = 16'(payload.size());
		f = '{cls, id, len[7:0], len[15:8]};
		foreach (payload[i]) f.push_back(payload[i]);
		a = '0;
		s = '0;
		foreach (f[i]) begin
			a = a + f[i];
			s = s + a;
		end
		f.push_front(UBX_SYNC2);
		f.push_front(UBX_SYNC1);
		f.push_back(a ^ flip_a);
		f.push_back(s ^ flip_b);
		return f;
	endfunction

	task automatic compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endtask

	// Check each report handed out against the oldest pending one, and stall
	// the report side at random.
	always @(posedge clk) begin : report_check
		frame_report_t want;
		if (arst_n === 1'b1 && dout.valid === 1'b1 && dout.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: report with status %0d arrived with none pending",
						$time, dout.frame_status);
			end else begin
				want = pending_reports.pop_front();
				compare_field("frame_status", want.status, dout.frame_status);
				compare_field("packet_class", want.pkt_class, dout.packet_class);
				compare_field("packet_id", want.pkt_id, dout.packet_id);
				compare_field("payload_length", want.pkt_len, dout.payload_length);
				compare_field("sentence_length", want.text_len, dout.sentence_length);
				compare_field("good_text_count", want.n_text, dout.good_text_count);
				compare_field("good_binary_count", want.n_bin, dout.good_binary_count);
				compare_field("error_count", want.n_err, dout.error_count);
				compare_field("byte_count", want.n_bytes, dout.byte_count);
			end
		end
		dout.ready <= steady || ($urandom_range(99) >= 9);
	end

	// Well-formed and checksum-corrupted frames of both kinds under the reset configuration.
	task automatic test_basic_frames();
		send_octets('{FILL_RESET, FILL_RESET, FILL_RESET});
		send_octets(nmea_frame(text_octets("GPGGA,123519,4807.038,N"), 1'b0, 8'h00));
		send_octets(nmea_frame(text_octets("GNRMC,A,5107.00"), 1'b1, 8'h00));
		send_octets(nmea_frame(text_octets(""), 1'b0, 8'h00));
		send_octets(nmea_frame(text_octets("GPVTG,054.7,T"), 1'b0, 8'h01));
		send_octets(ubx_frame(8'h00, 8'h00, random_bytes(0, 1'b0), 8'h00, 8'h00));
		send_octets(ubx_frame(8'hFF, 8'hFF, random_bytes(4, 1'b0), 8'h00, 8'h00));
		send_octets(ubx_frame(8'h01, 8'h07, random_bytes(6, 1'b0), 8'h80, 8'h00));
		send_octets(ubx_frame(8'h0A, 8'h04, random_bytes(3, 1'b0), 8'h00, 8'h01));
	endtask

	// Restarts, control characters before the star, missing star, bad digits.
	task automatic test_text_cases();
		octets_t body;
		send_octets(text_octets("$GPGSV,1,2"));
		send_octets(nmea_frame(text_octets("GPGSV,2,2"), 1'b0, 8'h00));
		send_octets(nmea_frame(text_octets("GP\015X"), 1'b0, 8'h00));
		body = text_octets("GPNUL");
		body.insert(2, CH_NUL);
		send_octets(nmea_frame(body, 1'b0, 8'h00));
		send_octets(nmea_frame(text_octets("AB\012CD"), 1'b0, 8'h00));
		send_octets(text_octets("$GPXX,1\015\012"));
		send_octets(text_octets("$A*G1\015\012"));
		send_octets(text_octets("$A*4Z\015\012"));
		send_octets(text_octets("$A*4\012"));
		send_octets(text_octets("$A*41XYZ\015\012"));
		send_octets(text_octets("$J*4a\015\012"));
		send_octets(text_octets("$\012"));
	endtask

	// Sync recovery, zero length, and a length with a nonzero high byte sent
	// without any idle cycles.
	task automatic test_ubx_cases();
		octets_t f;
		f = ubx_frame(8'h05, 8'h01, random_bytes(2, 1'b0), 8'h00, 8'h00);
		f.push_front(UBX_SYNC1);
		send_octets(f);
		send_octets('{UBX_SYNC1, 8'h41});
		send_octets('{UBX_SYNC1, FILL_RESET});
		send_octets(ubx_frame(8'h06, 8'h00, random_bytes(0, 1'b0), 8'h00, 8'h00));
		steady = 1'b1;
		send_octets(ubx_frame(8'h02, 8'h15, random_bytes(256, 1'b0), 8'h00, 8'h00));
		steady = 1'b0;
	endtask

	// Buffer size at and beyond both ends of its range.
	task automatic test_length_limit();
		write_reg(REG_LENGTH_LIMIT, LIMIT_MIN);
		send_octets(text_octets("$\012"));
		send_octets(text_octets("$ab"));
		send_octets(nmea_frame(text_octets(""), 1'b0, 8'h00));
		for (int v = 0; v < 3; v++) begin
			write_reg(REG_LENGTH_LIMIT, 9'(v));
			send_octets(text_octets("$ab\012"));
		end
		// Above the range the buffer holds 255 characters, so a sentence of 256
		// characters overflows at its newline.
		write_reg(REG_LENGTH_LIMIT, 9'd511);
		send_octets(nmea_frame(random_bytes(250, 1'b1), 1'b1, 8'h00));
		write_reg(REG_LENGTH_LIMIT, LIMIT_RESET);
	endtask

	// Fill values that collide with NUL and with the frame start bytes.
	task automatic test_idle_fill();
		octets_t body;
		write_reg(REG_IDLE_FILL, 9'h000);
		send_octets('{CH_NUL, CH_NUL});
		body = text_octets("GPZ");
		body.insert(1, CH_NUL);
		send_octets(nmea_frame(body, 1'b0, 8'h00));
		send_octets(nmea_frame(text_octets("GPOK"), 1'b0, 8'h00));
		write_reg(REG_IDLE_FILL, {1'b0, CH_DOLLAR});
		send_octets(nmea_frame(text_octets("GPGLL,1"), 1'b0, 8'h00));
		send_octets(ubx_frame(8'h01, 8'h02, random_bytes(3, 1'b0), 8'h00, 8'h00));
		write_reg(REG_IDLE_FILL, {1'b0, UBX_SYNC1});
		send_octets(ubx_frame(8'h01, 8'h03, random_bytes(2, 1'b0), 8'h00, 8'h00));
		send_octets(nmea_frame(text_octets("GPGLL,2"), 1'b0, 8'h00));
		write_reg(REG_IDLE_FILL, {1'b0, FILL_RESET});
	endtask

	// Mostly well-formed frames with random content, mixed with broken frames,
	// noise and fill, until the requested number of bytes has been taken.
	task automatic run_random_phase(input logic [8:0] limit, input logic [7:0] fill,
		input int target, input bit no_gaps);
		int         stop;
		int         lim;
		int         kind;
		int         n;
		int         pos;
		logic [7:0] c;
		octets_t    f;
		octets_t    body;
		write_reg(REG_LENGTH_LIMIT, limit);
		write_reg(REG_IDLE_FILL, {1'b0, fill});
		steady = no_gaps;
		lim = int'(eff_limit());
		stop = bytes_taken + target;
		while (bytes_taken < stop) begin
			kind = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? $urandom_range(lim - 1) : $urandom_range(20);
			body = random_bytes(n, 1'b1);
			f = nmea_frame(body, $urandom_range(1), 8'h00);
			if (kind < 35) begin
				// well-formed sentence, already built
			end else if (kind < 65) begin
				f = ubx_frame(8'($urandom), 8'($urandom), random_bytes($urandom_range(12), 1'b0),
					8'h00, 8'h00);
			end else if (kind < 70) begin
				f = nmea_frame(body, $urandom_range(1), 8'($urandom_range(255, 1)));
			end else if (kind < 73) begin
				c = ($urandom_range(2) == 0) ? CH_NUL : (($urandom_range(1) == 0) ? CH_CR : CH_LF);
				body.insert($urandom_range(body.size()), c);
				f = nmea_frame(body, 1'b0, 8'h00);
			end else if (kind < 75) begin
				f = body;
				f.push_front(CH_DOLLAR);
				f.push_back(CH_CR);
				f.push_back(CH_LF);
			end else if (kind < 78) begin
				pos = f.size() - 4 + $urandom_range(1);
				do c = 8'($urandom);
				while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
					(c >= "a" && c <= "f") || c == CH_DOLLAR);
				f[pos] = c;
			end else if (kind < 81) begin
				f = f[0:$urandom_range(f.size() - 2)];
			end else if (kind < 84) begin
				n = lim - 6 + $urandom_range(8);
				f = nmea_frame(random_bytes((n < 0) ? 0 : n, 1'b1), 1'b0, 8'h00);
			end else if (kind < 88) begin
				if ($urandom_range(1) == 0)
					f = ubx_frame(8'($urandom), 8'($urandom), random_bytes($urandom_range(8), 1'b0),
						8'($urandom_range(255, 1)), 8'h00);
				else
					f = ubx_frame(8'($urandom), 8'($urandom), random_bytes($urandom_range(8), 1'b0),
						8'h00, 8'($urandom_range(255, 1)));
			end else if (kind < 90) begin
				f = ubx_frame(8'($urandom), 8'($urandom), random_bytes($urandom_range(8), 1'b0),
					8'h00, 8'h00);
				f.push_front(UBX_SYNC1);
			end else if (kind < 92) begin
				do c = 8'($urandom);
				while (c == UBX_SYNC1 || c == UBX_SYNC2);
				f = '{UBX_SYNC1, c};
			end else if (kind < 96) begin
				f = random_bytes($urandom_range(4, 1), 1'b0);
			end else begin
				f.delete();
				repeat ($urandom_range(3, 1)) f.push_back(cfg_fill);
			end
			send_octets(f);
		end
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(LIMIT_RESET, FILL_RESET, 60, 1'b0);
		run_random_phase(9'($urandom_range(40, 12)), 8'($urandom), 70, 1'b0);
		run_random_phase(LIMIT_MIN, 8'h00, 40, 1'b0);
		run_random_phase(9'($urandom_range(48, 16)), 8'($urandom), 80, 1'b1);
		run_random_phase(9'($urandom_range(64, 20)), 8'($urandom), 80, 1'b0);
	endtask

	// Reset, run every test in turn, then drain and report.
	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_LENGTH_LIMIT;
		cfg_data    <= '0;
		din.valid   <= 1'b0;
		din.rx_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_text_cases();
		test_ubx_cases();
		test_length_limit();
		test_idle_fill();
		test_random_traffic();

		din.valid <= 1'b0;
		for (int k = 0; k < 1000 && pending_reports.size() != 0; k++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
